FILE: hdl/fmprt_pkg.sv
// Shared types and constants for the first-match packet rule table.
`default_nettype none
package fmprt_pkg;

  localparam int RULE_SLOTS = 128;
  localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int SLOT_W     = 7;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 16;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CHECK = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic              src_wild;
    logic [ADDR_W-1:0] src;
    logic              dst_wild;
    logic [ADDR_W-1:0] dst;
    logic              action;
    logic [PORT_W-1:0] port;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // packed from the lowest bit up: status, verdict, hit, hit_slot
  typedef struct packed {
    logic [SLOT_W-1:0] hit_slot;
    logic              hit;
    logic              verdict;
    logic              status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  typedef struct packed {
    logic accept;
    logic scan;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/fmprt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fmprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fmprt_ctrl.sv
// Controller state machine: accept, rule scan, result handoff.
`default_nettype none
module fmprt_ctrl
  import fmprt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [1:0] in_mode,
  input  wire logic       out_tready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;

  assign out_free = !stat.out_full || out_tready;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = (in_mode == MODE_CHECK) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd.out_load = out_free;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fmprt_dp.sv
// Datapath: rule memory, rule count, scan pipeline, result and output registers.
`default_nettype none
module fmprt_dp
  import fmprt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_mode,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 stat,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [ADDR_W-1:0] in_src, in_dst;
  logic [PORT_W-1:0] in_port;
  logic              in_src_wild, in_dst_wild, in_action;

  assign in_src      = in_tdata[31:0];
  assign in_src_wild = in_tdata[32];
  assign in_dst      = in_tdata[64:33];
  assign in_dst_wild = in_tdata[65];
  assign in_port     = in_tdata[81:66];
  assign in_action   = in_tdata[82];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [ADDR_W-1:0] key_src_r, key_src_nxt;
  logic [ADDR_W-1:0] key_dst_r, key_dst_nxt;
  logic [PORT_W-1:0] key_port_r, key_port_nxt;
  result_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r, out_data_nxt;

  logic              full, issue, match, scan_done, wr_en, rd_en;
  logic [IDX_W-1:0]  rd_addr;
  rule_t             wr_rule, rd_rule;
  logic [RULE_W-1:0] rd_word;

  assign full    = (count_r == CNT_W'(RULE_SLOTS));
  assign issue   = (rd_idx_r < count_r);
  assign rd_addr = rd_idx_r[IDX_W-1:0];
  assign wr_en   = cmd.accept && (in_mode == MODE_ADD) && !full;
  assign rd_en   = cmd.scan && issue;

  always_comb begin
    wr_rule          = '0;
    wr_rule.src_wild = in_src_wild;
    wr_rule.src      = in_src;
    wr_rule.dst_wild = in_dst_wild;
    wr_rule.dst      = in_dst;
    wr_rule.action   = in_action;
    wr_rule.port     = in_port;
  end

  fmprt_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_SLOTS)
  ) u_rule_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_rule),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_rule = rule_t'(rd_word);

  assign match = cmp_valid_r
              && (rd_rule.src_wild || (rd_rule.src == key_src_r))
              && (rd_rule.dst_wild || (rd_rule.dst == key_dst_r))
              && ((rd_rule.port == '0) || (rd_rule.port == key_port_r));

  assign scan_done = match || (!issue && !cmp_valid_r);

  assign stat.scan_done = scan_done;
  assign stat.out_full  = out_valid_r;

  always_comb begin
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    key_src_nxt   = key_src_r;
    key_dst_nxt   = key_dst_r;
    key_port_nxt  = key_port_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.accept) begin
      key_src_nxt   = in_src;
      key_dst_nxt   = in_dst;
      key_port_nxt  = in_port;
      rd_idx_nxt    = '0;
      cmp_valid_nxt = 1'b0;
      res_nxt       = '0;
      unique case (in_mode)
        MODE_ADD: begin
          if (full) begin
            res_nxt.status = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.scan) begin
      cmp_valid_nxt = issue;
      cmp_idx_nxt   = rd_addr;
      rd_idx_nxt    = rd_idx_r + CNT_W'(issue);
      if (scan_done) begin
        cmp_valid_nxt    = 1'b0;
        res_nxt          = '0;
        res_nxt.verdict  = match ? rd_rule.action : 1'b1;
        res_nxt.hit      = match;
        res_nxt.hit_slot = match ? SLOT_W'(cmp_idx_r) : '0;
      end
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    key_src_r  <= key_src_nxt;
    key_dst_r  <= key_dst_nxt;
    key_port_r <= key_port_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_data_r};

endmodule
`default_nettype wire

FILE: hdl/first_match_packet_rule_table_core.sv
// First-match packet rule table: top level joining controller and datapath.
//
// Input channel in_*: one item per handshake; in_tuser carries the mode
// (add rule, check packet, clear table), in_tdata the rule or packet fields.
// Output channel out_*: exactly one result item per input item, in order.
// Add appends a rule to a RULE_SLOTS-entry rule RAM (status 1 when full).
// Check reads the rules from slot 0 upward, one per cycle through the RAM
// read port, and stops at the first match; no match means deny.
// Clear only resets the rule count.
// Add, clear and unused mode go from accept straight to the result state;
// a check passes through the scan state first, which ends at the first match
// or once every stored rule has been compared.
// One item is in work at a time; in_tready is high while the controller is
// idle, so a new item is taken only once the last result has been loaded
// into the output register.
// The output register holds a finished result while the receiver stalls;
// the next item is accepted meanwhile and its result waits until that
// register is taken.
// Reset (synchronous, active low) empties the table; rule RAM needs no clearing.
`default_nettype none
module first_match_packet_rule_table_core
  import fmprt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // src_address[31:0], src_wild[32], dst_address[64:33], dst_wild[65],
  // port_number[81:66], rule_action[82], zero[87:83]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status[0], verdict[1], hit[2], hit_slot[9:3], zero[15:10]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  fmprt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  fmprt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_mode    (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: tb/sv/first_match_packet_rule_table_core_tb.sv
// Self-checking testbench for the first-match packet rule table core.
module first_match_packet_rule_table_core_tb
  import fmprt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         RANDOM_ITEMS = 500;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  typedef struct {
    logic [1:0] mode;
    rule_t      f;
    bit         known;
    result_t    res;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  rule_t      shadow_rules[RULE_SLOTS];
  int         shadow_count = 0;
  result_t    pending_results[$];
  dir_row_t   dir_rows[$];
  logic [31:0] addr_pool[4];
  result_t    want_res;
  result_t    got_res;
  int         err_count   = 0;
  int         cycle_count = 0;
  int         send_idle   = 8;
  int         recv_idle   = 55;

  first_match_packet_rule_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Updates the shadow table and returns the result the item should produce.
  function automatic result_t classify_item(logic [1:0] mode, rule_t f);
    result_t r;
    int      i;
    r = '0;
    case (mode)
      MODE_ADD: begin
        if (shadow_count >= RULE_SLOTS) begin
          r.status = 1'b1;
        end else begin
          shadow_rules[shadow_count] = f;
          shadow_count++;
        end
      end
      MODE_CHECK: begin
        r.verdict = 1'b1;
        for (i = 0; i < shadow_count && !r.hit; i++) begin
          if ((shadow_rules[i].src_wild || shadow_rules[i].src == f.src) &&
              (shadow_rules[i].dst_wild || shadow_rules[i].dst == f.dst) &&
              (shadow_rules[i].port == '0 || shadow_rules[i].port == f.port)) begin
            r.verdict  = shadow_rules[i].action;
            r.hit      = 1'b1;
            r.hit_slot = SLOT_W'(i);
          end
        end
      end
      MODE_CLEAR: begin
        shadow_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] mode, logic [31:0] src, logic sw,
                                      logic [31:0] dst, logic dw, logic [15:0] port,
                                      logic act, bit known = 1'b0, logic st = 1'b0,
                                      logic vd = 1'b0, logic ht = 1'b0,
                                      logic [SLOT_W-1:0] sl = '0);
    dir_row_t row;
    row.mode           = mode;
    row.f.src          = src;
    row.f.src_wild     = sw;
    row.f.dst          = dst;
    row.f.dst_wild     = dw;
    row.f.port         = port;
    row.f.action       = act;
    row.known          = known;
    row.res.status     = st;
    row.res.verdict    = vd;
    row.res.hit        = ht;
    row.res.hit_slot   = sl;
    return row;
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(2) == 0) begin
      return $urandom;
    end
    return addr_pool[$urandom_range(3)];
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(3))
      0: begin
        return 16'h0;
      end
      1: begin
        return 16'($urandom_range(1, 3));
      end
      default: begin
        return 16'($urandom_range(65535));
      end
    endcase
  endfunction

  function automatic rule_t make_rule();
    rule_t r;
    r.src      = pick_addr();
    r.src_wild = ($urandom_range(3) == 0);
    r.dst      = pick_addr();
    r.dst_wild = ($urandom_range(3) == 0);
    r.port     = pick_port();
    r.action   = 1'($urandom_range(1));
    return r;
  endfunction

  // Mostly aims a packet at a stored rule so earlier rules may shadow it.
  function automatic rule_t make_probe();
    rule_t p;
    rule_t r;
    p = make_rule();
    if (shadow_count > 0 && $urandom_range(9) < 7) begin
      r = shadow_rules[$urandom_range(shadow_count - 1)];
      if (!r.src_wild) begin
        p.src = r.src;
      end
      if (!r.dst_wild) begin
        p.dst = r.dst;
      end
      if (r.port != '0) begin
        p.port = r.port;
      end
    end
    return p;
  endfunction

  task automatic send_item(logic [1:0] mode, rule_t f, bit known = 1'b0,
                           result_t known_res = '0);
    result_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {5'b0, f.action, f.port, f.dst_wild, f.dst, f.src_wild, f.src};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    predicted = classify_item(mode, f);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  task automatic report(string what, logic [15:0] wantv, logic [15:0] gotv);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, wantv, gotv);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", '0, out_tdata);
      end else begin
        want_res = pending_results.pop_front();
        got_res  = result_t'(out_tdata[RESULT_W-1:0]);
        if (got_res.status !== want_res.status) begin
          report("status", 16'(want_res.status), 16'(got_res.status));
        end
        if (got_res.verdict !== want_res.verdict) begin
          report("verdict", 16'(want_res.verdict), 16'(got_res.verdict));
        end
        if (got_res.hit !== want_res.hit) begin
          report("hit", 16'(want_res.hit), 16'(got_res.hit));
        end
        if (got_res.hit_slot !== want_res.hit_slot) begin
          report("hit_slot", 16'(want_res.hit_slot), 16'(got_res.hit_slot));
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int rnd_items;
    int episode;
    int n_add;
    int n_chk;

    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = $urandom;
    addr_pool[3] = $urandom;

    // known results: empty table, unused mode, plain adds and clears
    dir_rows.push_back(mk_row(MODE_CHECK, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0,
                              1'b1, 1'b0, 1'b1, 1'b0, 7'd0));
    dir_rows.push_back(mk_row(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                              16'hFFFF, 1'b1, 1'b1));
    dir_rows.push_back(mk_row(MODE_CLEAR, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(MODE_ADD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0,
                              16'hFFFF, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(MODE_ADD, 32'h0, 1'b0, 32'h0, 1'b0, 16'h1, 1'b1, 1'b1));
    dir_rows.push_back(mk_row(MODE_ADD, 32'h1234_5678, 1'b1, 32'h8765_4321, 1'b1,
                              16'h0, 1'b1, 1'b1));
    dir_rows.push_back(mk_row(MODE_CHECK, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0,
                              16'hFFFF, 1'b0));
    dir_rows.push_back(mk_row(MODE_CHECK, 32'h0, 1'b0, 32'h0, 1'b0, 16'h1, 1'b0));
    // packet port zero skips the port-1 rule
    dir_rows.push_back(mk_row(MODE_CHECK, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0));
    // flags on a check are don't-care
    dir_rows.push_back(mk_row(MODE_CHECK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                              16'hFFFE, 1'b1));
    dir_rows.push_back(mk_row(MODE_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                              16'hFFFF, 1'b1, 1'b1));
    // stale rules must not be seen after a clear
    dir_rows.push_back(mk_row(MODE_CHECK, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0,
                              16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 7'd0));
    dir_rows.push_back(mk_row(MODE_ADD, 32'h0, 1'b1, 32'hA5A5_A5A5, 1'b0, 16'h0, 1'b0));
    dir_rows.push_back(mk_row(MODE_ADD, 32'h5A5A_5A5A, 1'b0, 32'h0, 1'b1, 16'h8000,
                              1'b1));
    dir_rows.push_back(mk_row(MODE_CHECK, 32'h0F0F_0F0F, 1'b0, 32'hA5A5_A5A5, 1'b0,
                              16'h1234, 1'b0));
    dir_rows.push_back(mk_row(MODE_CHECK, 32'h5A5A_5A5A, 1'b0, 32'h0, 1'b0, 16'h8000,
                              1'b0));
    dir_rows.push_back(mk_row(MODE_CHECK, 32'h5A5A_5A5A, 1'b0, 32'h0, 1'b0, 16'h8001,
                              1'b0));
    dir_rows.push_back(mk_row(MODE_UNUSED, 32'h5A5A_5A5A, 1'b0, 32'hA5A5_A5A5, 1'b0,
                              16'h0, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(MODE_CHECK, 32'h5A5A_5A5A, 1'b0, 32'hA5A5_A5A5, 1'b0,
                              16'h0, 1'b0));
    dir_rows.push_back(mk_row(MODE_CLEAR, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0, 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].mode, dir_rows[k].f, dir_rows[k].known, dir_rows[k].res);
    end

    rnd_items = 0;
    episode   = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      if (rnd_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (rnd_items >= RANDOM_ITEMS / 3) begin
        send_idle = 55;
        recv_idle = 8;
      end
      if (episode == 0 || $urandom_range(19) == 0) begin
        // fill the table and push past it
        n_add = RULE_SLOTS - shadow_count + $urandom_range(1, 3);
      end else begin
        if ($urandom_range(2) == 0) begin
          send_item(MODE_CLEAR, make_rule());
          rnd_items++;
        end
        n_add = $urandom_range(12);
      end
      repeat (n_add) begin
        send_item(MODE_ADD, make_rule());
        rnd_items++;
      end
      n_chk = $urandom_range(4, 12);
      repeat (n_chk) begin
        if ($urandom_range(19) == 0) begin
          send_item(MODE_UNUSED, make_rule());
        end
        send_item(MODE_CHECK, make_probe());
        rnd_items++;
      end
      episode++;
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (RULE_SLOTS + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
